// ----- hw/rtl/jsu_pkg.sv -----
package jsu_pkg;

    // Decoder position within one string body
    typedef enum logic [2:0] {
        MODE_OPEN = 3'd0,
        MODE_BODY = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX0 = 3'd3,
        MODE_HEX1 = 3'd4,
        MODE_HEX2 = 3'd5,
        MODE_HEX3 = 3'd6
    } jsu_mode_t;

    localparam int unsigned MaxBeats = 3;

    // One result beat as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       str_end;
        logic       run_last;
    } jsu_beat_t;

    // Everything the decoder hands back for one source byte
    typedef struct packed {
        logic [1:0]                   count;
        jsu_beat_t [MaxBeats-1:0]     beats;
        jsu_mode_t                    mode;
        logic [15:0]                  hex;
    } jsu_dec_t;

endpackage

// ----- hw/rtl/jsu_decode.sv -----
module jsu_decode (
    input  jsu_pkg::jsu_mode_t mode,
    input  logic [15:0]        hex,
    input  logic [7:0]         in_byte,
    input  logic [2:0]         bytes_after,
    output jsu_pkg::jsu_dec_t  dec
);
    import jsu_pkg::*;

    localparam logic [7:0]  ChQuote = 8'h22;
    localparam logic [7:0]  ChBslash = 8'h5C;
    localparam logic [7:0]  ChU = 8'h75;
    localparam logic [7:0]  ChN = 8'h6E;
    localparam logic [7:0]  ChT = 8'h74;
    localparam logic [7:0]  ChR = 8'h72;
    localparam logic [15:0] Utf8TwoMin = 16'h0080;
    localparam logic [15:0] Utf8ThreeMin = 16'h0800;
    localparam logic [7:0]  Lead2 = 8'hC0;
    localparam logic [7:0]  Lead3 = 8'hE0;
    localparam logic [7:0]  Cont = 8'h80;
    localparam logic [7:0]  ContMask = 8'h3F;

    logic        buf_last;
    logic        closes;
    logic [1:0]  n;
    logic [15:0] code;
    logic [7:0]  mapped;

    // Hex digit value; anything else counts as zero
    function automatic logic [3:0] hex_val(input logic [7:0] h);
        logic [3:0] v;
        v = 4'd0;
        if (h >= 8'h30 && h <= 8'h39) v = 4'(h - 8'h30);
        else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h57);
        else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h37);
        return v;
    endfunction

    assign buf_last = (bytes_after == 3'd0);
    assign code     = {hex[11:0], hex_val(in_byte)};

    // Map single-letter escapes
    always_comb begin
        case (in_byte)
            ChN:     mapped = 8'h0A;
            ChT:     mapped = 8'h09;
            ChR:     mapped = 8'h0D;
            default: mapped = in_byte;
        endcase
    end

    // Decode one source byte into up to three beats and the next state
    always_comb begin
        dec    = '0;
        dec.mode = mode;
        dec.hex  = hex;
        closes = 1'b0;
        n      = 2'd0;
        case (mode)
            MODE_BODY: begin
                if (in_byte == ChQuote) begin
                    closes = 1'b1;
                end else if (in_byte == ChBslash && !buf_last) begin
                    dec.mode = MODE_ESC;
                end else begin
                    dec.beats[0].data = in_byte;
                    dec.beats[0].has  = 1'b1;
                    n = 2'd1;
                end
            end
            MODE_ESC: begin
                if (in_byte == ChU) begin
                    if (bytes_after >= 3'd4) begin
                        dec.hex  = '0;
                        dec.mode = MODE_HEX0;
                    end else begin
                        dec.mode = MODE_BODY;
                    end
                end else begin
                    dec.beats[0].data = mapped;
                    dec.beats[0].has  = 1'b1;
                    n = 2'd1;
                    dec.mode = MODE_BODY;
                end
            end
            MODE_HEX0: begin
                dec.hex  = code;
                dec.mode = MODE_HEX1;
            end
            MODE_HEX1: begin
                dec.hex  = code;
                dec.mode = MODE_HEX2;
            end
            MODE_HEX2: begin
                dec.hex  = code;
                dec.mode = MODE_HEX3;
            end
            MODE_HEX3: begin
                dec.hex  = code;
                dec.mode = MODE_BODY;
                if (code < Utf8TwoMin) begin
                    dec.beats[0].data = code[7:0];
                    dec.beats[0].has  = 1'b1;
                    n = 2'd1;
                end else if (code < Utf8ThreeMin) begin
                    dec.beats[0].data = Lead2 | {3'b000, code[10:6]};
                    dec.beats[1].data = Cont | (code[7:0] & ContMask);
                    dec.beats[0].has  = 1'b1;
                    dec.beats[1].has  = 1'b1;
                    n = 2'd2;
                end else begin
                    dec.beats[0].data = Lead3 | {4'b0000, code[15:12]};
                    dec.beats[1].data = Cont | (code[13:6] & ContMask);
                    dec.beats[2].data = Cont | (code[7:0] & ContMask);
                    dec.beats[0].has  = 1'b1;
                    dec.beats[1].has  = 1'b1;
                    dec.beats[2].has  = 1'b1;
                    n = 2'd3;
                end
            end
            default: begin
                // opening byte skipped unchecked
                dec.mode = MODE_BODY;
            end
        endcase

        // Close the string on a quote or at buffer end
        if (buf_last) closes = 1'b1;
        if (closes) begin
            if (n == 2'd0) n = 2'd1;
            case (n)
                2'd1:    dec.beats[0].str_end = 1'b1;
                2'd2:    dec.beats[1].str_end = 1'b1;
                default: dec.beats[2].str_end = 1'b1;
            endcase
            dec.mode = MODE_OPEN;
            dec.hex  = '0;
        end

        // Tag the final beat of this byte
        case (n)
            2'd1:    dec.beats[0].run_last = 1'b1;
            2'd2:    dec.beats[1].run_last = 1'b1;
            2'd3:    dec.beats[2].run_last = 1'b1;
            default: ;
        endcase
        dec.count = n;
    end

endmodule

// ----- hw/rtl/json_string_unescape.sv -----
// Channel | Direction | Ports                                       | Beat
// s_      | in        | s_valid s_ready s_in_byte s_bytes_after     | one source byte
// m_      | out       | m_valid m_ready m_out_byte m_has_byte       | one result
//         |           | m_string_end m_run_last                     |
// A source byte is decoded in the cycle it is taken; its 0 to 3 results sit in a
// three-entry result register, held while m_ready stalls, and leave one per cycle
// from the next cycle on. Throughput is one byte per cycle while each byte yields at
// most one result; a byte with more, as a \u escape closing in two- or three-byte
// UTF-8, holds input until only its last is left. aresetn (synchronous, active low)
// empties the result register and returns the decoder to wait for an opening byte.
module json_string_unescape (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic [2:0] s_bytes_after,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_string_end,
    output logic       m_run_last
);
    import jsu_pkg::*;

    jsu_mode_t   mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  cnt_reg, cnt_next;
    jsu_beat_t [MaxBeats-1:0] beat_reg, beat_next;
    jsu_dec_t    dec;
    logic        s_fire, m_fire;

    jsu_decode u_decode (
        .mode        (mode_reg),
        .hex         (hex_reg),
        .in_byte     (s_in_byte),
        .bytes_after (s_bytes_after),
        .dec         (dec)
    );

    assign m_fire  = m_valid && m_ready;
    assign s_fire  = s_valid && s_ready;
    // Take a byte once the held results are gone or the last one leaves now
    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign m_valid = (cnt_reg != 2'd0);

    assign m_out_byte   = beat_reg[0].data;
    assign m_has_byte   = beat_reg[0].has;
    assign m_string_end = beat_reg[0].str_end;
    assign m_run_last   = beat_reg[0].run_last;

    // Load a fresh group of results, or advance the held ones
    always_comb begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        cnt_next  = cnt_reg;
        beat_next = beat_reg;
        if (s_fire) begin
            mode_next = dec.mode;
            hex_next  = dec.hex;
            cnt_next  = dec.count;
            beat_next = dec.beats;
        end else if (m_fire) begin
            cnt_next     = cnt_reg - 2'd1;
            beat_next[0] = beat_reg[1];
            beat_next[1] = beat_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_OPEN;
            hex_reg  <= '0;
            cnt_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

    // A string always closes on the final result of its byte
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_end |-> m_run_last)
        else $error("string end on a result that is not the last of its byte");

    // An empty result only ever marks a string end, with a zero byte
    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_string_end && m_out_byte == 8'd0)
        else $error("empty result without string end");

    // Buffer end always sends the decoder back to the opening byte
    a_buf_end_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_bytes_after == 3'd0 |=> mode_reg == MODE_OPEN && hex_reg == 16'd0)
        else $error("decoder not reset to opening byte after buffer end");

    // No byte is taken while more than one result is still held
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg > 2'd1 |-> !s_ready)
        else $error("input accepted over held results");

endmodule

// ----- test/tb_json_string_unescape.sv -----
module tb_json_string_unescape;
    import jsu_pkg::*;

    // Characters the decoder treats specially
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // UTF-8 encoding pieces
    localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [7:0]  UTF8_CONT_MASK = 8'h3F;

    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 48;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned ITEM_GOAL    = 170;

    // Tracks the decoder state and the result beats still owed by the block
    class unescape_scoreboard;
        jsu_mode_t   mode;
        logic [15:0] code;
        jsu_beat_t   owed_q[$];
        int          n_bytes;
        int          n_beats;
        int          n_strings;
        int          n_errors;

        function new();
            mode = MODE_OPEN;
            code = '0;
        endfunction

        function jsu_beat_t data_beat(input logic [7:0] d);
            jsu_beat_t b;
            b = '0;
            b.data = d;
            b.has = 1'b1;
            return b;
        endfunction

        // Decode one accepted source byte and queue the beats it causes
        function void note_byte(input logic [7:0] b, input logic [2:0] after);
            jsu_beat_t   row [MaxBeats];
            int          n;
            logic        closes;
            logic [15:0] nxt;
            logic [3:0]  nib;
            n = 0;
            closes = (after == 3'd0);
            n_bytes++;
            case (mode)
                MODE_BODY: begin
                    if (b == CH_QUOTE) begin
                        closes = 1'b1;
                    end else if (b == CH_BSLASH && after != 3'd0) begin
                        mode = MODE_ESC;
                    end else begin
                        row[n] = data_beat(b);
                        n = n + 1;
                    end
                end
                MODE_ESC: begin
                    if (b == CH_U) begin
                        if (after >= 3'd4) begin
                            code = '0;
                            mode = MODE_HEX0;
                        end else begin
                            mode = MODE_BODY;
                        end
                    end else begin
                        case (b)
                            CH_N:    row[n] = data_beat(CH_LF);
                            CH_T:    row[n] = data_beat(CH_TAB);
                            CH_R:    row[n] = data_beat(CH_CR);
                            default: row[n] = data_beat(b);
                        endcase
                        n = n + 1;
                        mode = MODE_BODY;
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                    // a non-hex digit still shifts, adding nothing
                    if (b >= "0" && b <= "9") nib = 4'(b - "0");
                    else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
                    else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
                    else nib = 4'd0;
                    nxt = {code[11:0], nib};
                    code = nxt;
                    if (mode == MODE_HEX3) begin
                        if (nxt < UTF8_ONE_LIMIT) begin
                            row[0] = data_beat(nxt[7:0]);
                            n = 1;
                        end else if (nxt < UTF8_TWO_LIMIT) begin
                            row[0] = data_beat(UTF8_LEAD2 | 8'(nxt >> 6));
                            row[1] = data_beat(UTF8_CONT | (nxt[7:0] & UTF8_CONT_MASK));
                            n = 2;
                        end else begin
                            row[0] = data_beat(UTF8_LEAD3 | 8'(nxt >> 12));
                            row[1] = data_beat(UTF8_CONT | (8'(nxt >> 6) & UTF8_CONT_MASK));
                            row[2] = data_beat(UTF8_CONT | (nxt[7:0] & UTF8_CONT_MASK));
                            n = 3;
                        end
                        mode = MODE_BODY;
                    end else begin
                        mode = jsu_mode_t'(mode + 3'd1);
                    end
                end
                default: begin
                    mode = MODE_BODY;
                end
            endcase
            // close the string on a quote or at buffer end
            if (closes) begin
                if (n == 0) begin
                    row[0] = '0;
                    n = 1;
                end
                row[n-1].str_end = 1'b1;
                mode = MODE_OPEN;
                code = '0;
                n_strings++;
            end
            if (n > 0) row[n-1].run_last = 1'b1;
            for (int i = 0; i < n; i++) owed_q = {owed_q, row[i]};
        endfunction

        // Compare one result beat with the oldest owed beat
        function void check_beat(input jsu_beat_t got);
            jsu_beat_t exp_beat;
            n_beats++;
            if (owed_q.size() == 0) begin
                $error("result beat with nothing owed: out_byte %02h has_byte %0b",
                       got.data, got.has);
                n_errors++;
                return;
            end
            exp_beat = owed_q.pop_front();
            if (got.data !== exp_beat.data) begin
                $error("out_byte: expected %02h, got %02h", exp_beat.data, got.data);
                n_errors++;
            end
            if (got.has !== exp_beat.has) begin
                $error("has_byte: expected %0b, got %0b", exp_beat.has, got.has);
                n_errors++;
            end
            if (got.str_end !== exp_beat.str_end) begin
                $error("string_end: expected %0b, got %0b", exp_beat.str_end, got.str_end);
                n_errors++;
            end
            if (got.run_last !== exp_beat.run_last) begin
                $error("run_last: expected %0b, got %0b", exp_beat.run_last, got.run_last);
                n_errors++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = '0;
    logic [2:0] s_bytes_after = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_has_byte;
    logic       m_string_end;
    logic       m_run_last;

    unescape_scoreboard sb = new();

    logic [7:0] src_bytes[$];
    int         n_sent = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    int         quiet_cycles = 0;
    int         hold_left = 0;
    logic       hold_start = 1'b0;
    logic       hold_started = 1'b0;

    json_string_unescape u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_bytes_after (s_bytes_after),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_has_byte    (m_has_byte),
        .m_string_end  (m_string_end),
        .m_run_last    (m_run_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_start && !hold_started) begin
            hold_started <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watch both channels; stop the run if traffic dries up
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_beat('{data: m_out_byte, has: m_has_byte,
                                str_end: m_string_end, run_last: m_run_last});
            end
            if (s_valid && s_ready) begin
                sb.note_byte(s_in_byte, s_bytes_after);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Append one byte to the buffer being built
    function automatic void add_src(input logic [7:0] ch);
        src_bytes = {src_bytes, ch};
    endfunction

    // Offer one source byte, with random idle cycles first; return once taken
    task automatic send_beat(input logic [7:0] b, input logic [2:0] after);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_bytes_after <= after;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // Send the queued buffer with a matching remaining-byte count
    task automatic send_buffer(input bit wide_counts);
        int left;
        logic [2:0] after;
        for (int i = 0; i < src_bytes.size(); i++) begin
            left = src_bytes.size() - 1 - i;
            if (left < 4) after = 3'(left);
            else if (wide_counts && $urandom_range(4) == 0) after = 3'($urandom_range(5, 7));
            else after = 3'd4;
            send_beat(src_bytes[i], after);
        end
    endtask

    task automatic send_text(input string s);
        src_bytes = {};
        for (int i = 0; i < s.len(); i++) add_src(s[i]);
        send_buffer(1'b0);
    endtask

    // Append one string: opening byte, random tokens, usually a closing quote
    task automatic add_string();
        int          pick;
        logic [15:0] cp;
        logic [3:0]  nib;
        logic [7:0]  ch;
        add_src($urandom_range(9) == 0 ? 8'($urandom_range(255)) : CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                ch = 8'($urandom_range(255));
                if (ch == CH_QUOTE || ch == CH_BSLASH) ch = "a";
                add_src(ch);
            end else if (pick < 65) begin
                add_src(CH_BSLASH);
                case ($urandom_range(9))
                    0: add_src(CH_N);
                    1: add_src(CH_T);
                    2: add_src(CH_R);
                    3: add_src(CH_QUOTE);
                    4: add_src(CH_BSLASH);
                    5: add_src("/");
                    6: add_src(CH_U);
                    default: add_src(8'($urandom_range(255)));
                endcase
            end else begin
                add_src(CH_BSLASH);
                add_src(CH_U);
                case ($urandom_range(2))
                    0: cp = 16'($urandom_range(16'h007F));
                    1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
                    default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
                endcase
                for (int d = 3; d >= 0; d--) begin
                    nib = cp[d*4 +: 4];
                    if ($urandom_range(9) == 0) ch = 8'($urandom_range(255));
                    else if (nib < 4'd10) ch = "0" + 8'(nib);
                    else if ($urandom_range(1) == 0) ch = "A" + 8'(nib) - 8'd10;
                    else ch = "a" + 8'(nib) - 8'd10;
                    add_src(ch);
                end
            end
        end
        if ($urandom_range(4) != 0) add_src(CH_QUOTE);
    endtask

    // Mostly well-formed buffers, some cut short, some pure noise
    task automatic send_random(input int goal);
        int keep;
        logic [7:0] ch;
        while (n_sent < goal) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(3))
                        0: ch = CH_QUOTE;
                        1: ch = CH_BSLASH;
                        2: ch = CH_U;
                        default: ch = 8'($urandom_range(255));
                    endcase
                    send_beat(ch, 3'($urandom_range(7)));
                end
            end else begin
                src_bytes = {};
                repeat ($urandom_range(1, 3)) add_string();
                if ($urandom_range(4) == 0) begin
                    keep = $urandom_range(1, src_bytes.size());
                    while (src_bytes.size() > keep) void'(src_bytes.pop_back());
                end
                send_buffer(1'b1);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty string at buffer end, on an all-ones opening byte
        send_beat(8'hFF, 3'd0);
        // three-byte UTF-8, buffer ends on the last hex digit
        send_text("\"\\u20AC");
        // quote and a non-hex letter among the hex digits, two-byte UTF-8
        send_text("\"\\u0\"Az");
        // tab, quote and slash escapes, closing quote, then an empty string
        send_text("\"\\t\\\"\\/\"x");
        // short u escape followed by a trailing backslash
        send_text("\"\\u\\");
        // buffer end inside hex digits, zero opening byte, wide counts
        send_beat(8'h00, 3'd7);
        send_beat(CH_BSLASH, 3'd5);
        send_beat(CH_U, 3'd6);
        send_beat("1", 3'd0);

        // no idling, with a long receiver hold-off at the start
        hold_start <= 1'b1;
        send_random(n_sent + (ITEM_GOAL - n_sent) / 4);
        src_idle_pct = 70;
        send_random(n_sent + (ITEM_GOAL - n_sent) / 3);
        src_idle_pct = 0;
        sink_stall_pct = 70;
        send_random(n_sent + (ITEM_GOAL - n_sent) / 2);
        src_idle_pct = 26;
        sink_stall_pct = 26;
        send_random(ITEM_GOAL);
        s_valid <= 1'b0;

        // drain owed beats, then watch for strays
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Decoded %0d source bytes into %0d result beats over %0d strings",
                 sb.n_bytes, sb.n_beats, sb.n_strings);
        $display("Covered escapes, \\u forms, buffer ends, idle/stall mixes and a long hold-off");
        if (sb.n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- json_string_unescape.f -----
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/json_string_unescape.sv
test/tb_json_string_unescape.sv
